### design/dlsf_pkg.sv
// Shared types, constants and the sigmoid breakpoint table for the dense layer unit.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps

package dlsf_pkg;

	localparam int MAX_INPUTS   = 64;
	localparam int MAX_OUTPUTS  = 16;
	localparam int WEIGHT_DEPTH = MAX_OUTPUTS * (MAX_INPUTS + 1);

	// field widths of the words on the channels
	localparam int CMD_W   = 2;
	localparam int IDX_W   = 11;
	localparam int VAL_W   = 16;
	localparam int NEU_W   = 4;
	localparam int PRE_W   = 24;
	localparam int ACT_W   = 16;
	localparam int SRC_W   = 7;
	localparam int TGT_W   = 5;

	// internal widths
	localparam int TERM_W  = $clog2(MAX_INPUTS + 1);
	localparam int XA_W    = $clog2(MAX_INPUTS);
	localparam int WA_W    = $clog2(WEIGHT_DEPTH);
	localparam int NCNT_W  = $clog2(MAX_OUTPUTS + 1);
	localparam int NIDX_W  = $clog2(MAX_OUTPUTS);
	localparam int PROD_W  = 2 * VAL_W;
	localparam int ACC_W   = PROD_W + $clog2(MAX_INPUTS + 1);
	localparam int DIFF_W  = 13;
	localparam int FRAC_W  = 11;
	localparam int INTERP_W = DIFF_W + FRAC_W;

	// command codes
	localparam logic [CMD_W-1:0] CMD_WEIGHT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_INPUT  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RUN    = 2'd2;

	// register selects (address bit 2)
	localparam logic REG_SOURCE = 1'b0;
	localparam logic REG_TARGET = 1'b1;

	localparam logic [SRC_W-1:0] SOURCE_RESET = 7'd64;
	localparam logic [TGT_W-1:0] TARGET_RESET = 5'd16;

	// 1.0 in Q4.12, multiplies the bias into the Q8.24 sum
	localparam logic signed [VAL_W-1:0] ONE_Q12 = 16'sd4096;

	localparam logic signed [PRE_W-1:0] PRE_MAX = 24'sh7FFFFF;
	localparam logic signed [PRE_W-1:0] PRE_MIN = -24'sh800000;

	typedef enum logic [1:0] {
		S_IDLE,
		S_MAC,
		S_DRAIN,
		S_EMIT
	} dlsf_state_t;

	// controller -> datapath
	typedef struct packed {
		logic              wr_weight;
		logic              wr_input;
		logic              mac_en;
		logic              first;
		logic              bias;
		logic [WA_W-1:0]   waddr;
		logic [XA_W-1:0]   xaddr;
		logic              emit;
		logic [NEU_W-1:0]  neuron;
		logic              last;
	} dlsf_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic done;
		logic out_busy;
	} dlsf_stat_t;

	// sigmoid(k/2) for k = -16..16 in Q0.16, index k+16
	function automatic logic [ACT_W-1:0] sig_tab(input logic [5:0] k);
		logic [ACT_W-1:0] r;
		case (k)
			6'd0:  r = 16'd22;
			6'd1:  r = 16'd36;
			6'd2:  r = 16'd60;
			6'd3:  r = 16'd98;
			6'd4:  r = 16'd162;
			6'd5:  r = 16'd267;
			6'd6:  r = 16'd439;
			6'd7:  r = 16'd720;
			6'd8:  r = 16'd1179;
			6'd9:  r = 16'd1921;
			6'd10: r = 16'd3108;
			6'd11: r = 16'd4971;
			6'd12: r = 16'd7812;
			6'd13: r = 16'd11955;
			6'd14: r = 16'd17625;
			6'd15: r = 16'd24743;
			6'd16: r = 16'd32768;
			6'd17: r = 16'd40793;
			6'd18: r = 16'd47911;
			6'd19: r = 16'd53581;
			6'd20: r = 16'd57724;
			6'd21: r = 16'd60565;
			6'd22: r = 16'd62428;
			6'd23: r = 16'd63615;
			6'd24: r = 16'd64357;
			6'd25: r = 16'd64816;
			6'd26: r = 16'd65097;
			6'd27: r = 16'd65269;
			6'd28: r = 16'd65374;
			6'd29: r = 16'd65438;
			6'd30: r = 16'd65476;
			6'd31: r = 16'd65500;
			6'd32: r = 16'd65514;
			default: r = 16'd65514;
		endcase
		return r;
	endfunction

endpackage

### design/dlsf_in_if.sv
// Input channel of the dense layer unit: valid/ready plus command, index, value.
// Depends on dlsf_pkg for field widths.
`timescale 1ns / 1ps

interface dlsf_in_if import dlsf_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [CMD_W-1:0]        command;
	logic [IDX_W-1:0]        index;
	logic signed [VAL_W-1:0] value;

	modport source (output valid, command, index, value, input ready);
	modport sink   (input valid, command, index, value, output ready);
endinterface

### design/dlsf_out_if.sv
// Result channel of the dense layer unit: valid/ready plus neuron, sums and sigmoid.
// Depends on dlsf_pkg for field widths.
`timescale 1ns / 1ps

interface dlsf_out_if import dlsf_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [NEU_W-1:0]        neuron;
	logic signed [PRE_W-1:0] pre_activation;
	logic [ACT_W-1:0]        activation;
	logic                    last;

	modport source (output valid, neuron, pre_activation, activation, last, input ready);
	modport sink   (input valid, neuron, pre_activation, activation, last, output ready);
endinterface

### design/dlsf_datapath.sv
// Datapath: weight and activation memories, MAC pipeline, rounding, sigmoid, output word.
// Depends on dlsf_pkg; driven by dlsf_ctrl through dlsf_cmd_t.
`timescale 1ns / 1ps

module dlsf_datapath import dlsf_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  dlsf_cmd_t               cmd,
	output dlsf_stat_t              stat,
	input  logic [IDX_W-1:0]        in_index,
	input  logic signed [VAL_W-1:0] in_value,
	input  logic                    out_ready,
	output logic                    out_valid,
	output logic [NEU_W-1:0]        out_neuron,
	output logic signed [PRE_W-1:0] out_pre,
	output logic [ACT_W-1:0]        out_act,
	output logic                    out_last
);

	logic signed [VAL_W-1:0] wmem [WEIGHT_DEPTH];
	logic signed [VAL_W-1:0] xmem [MAX_INPUTS];

	logic signed [VAL_W-1:0]  w_s1, x_s1;
	logic                     v_s1, first_s1, bias_s1;
	logic signed [PROD_W-1:0] prod_s2;
	logic                     v_s2, first_s2, bias_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic                     done_s3;
	logic signed [PRE_W-1:0]  sum_s4;
	logic                     done_s4;
	logic signed [PRE_W-1:0]  sum_s5;
	logic [ACT_W-1:0]         lo_s5;
	logic [DIFF_W-1:0]        diff_s5;
	logic [FRAC_W-1:0]        frac_s5;
	logic                     done_s5;
	logic signed [PRE_W-1:0]  sum_s6;
	logic [ACT_W-1:0]         lo_s6;
	logic [INTERP_W-1:0]      interp_s6;
	logic                     done_s6;

	logic                     wr_w_ok, wr_x_ok;
	logic signed [VAL_W-1:0]  mul_b;
	logic signed [ACC_W-1:0]  acc_rnd;
	logic signed [ACC_W-13:0] acc_shr;
	logic signed [PRE_W-1:0]  sum_sat;
	logic [15:0]              off;
	logic [5:0]               seg;
	logic [ACT_W-1:0]         tab_lo, tab_hi, lo_sel;
	logic [DIFF_W-1:0]        diff_sel;
	logic [FRAC_W-1:0]        frac_sel;
	logic [INTERP_W:0]        interp_rnd;

	// writes outside the stores are dropped
	assign wr_w_ok = cmd.wr_weight && ({1'b0, in_index} < (IDX_W+1)'(WEIGHT_DEPTH));
	assign wr_x_ok = cmd.wr_input && ({1'b0, in_index} < (IDX_W+1)'(MAX_INPUTS));

	always_ff @(posedge clk) begin
		if (wr_w_ok)
			wmem[in_index[WA_W-1:0]] <= in_value;
		w_s1 <= wmem[cmd.waddr];
	end

	always_ff @(posedge clk) begin
		if (wr_x_ok)
			xmem[in_index[XA_W-1:0]] <= in_value;
		x_s1 <= xmem[cmd.xaddr];
	end

	// bias slot multiplies by 1.0
	assign mul_b = bias_s1 ? ONE_Q12 : x_s1;

	always_ff @(posedge clk) begin
		prod_s2 <= w_s1 * mul_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			first_s1 <= 1'b0;
			bias_s1  <= 1'b0;
			v_s2     <= 1'b0;
			first_s2 <= 1'b0;
			bias_s2  <= 1'b0;
			done_s3  <= 1'b0;
			done_s4  <= 1'b0;
			done_s5  <= 1'b0;
			done_s6  <= 1'b0;
		end else begin
			v_s1     <= cmd.mac_en;
			first_s1 <= cmd.first;
			bias_s1  <= cmd.bias;
			v_s2     <= v_s1;
			first_s2 <= first_s1;
			bias_s2  <= bias_s1;
			done_s3  <= v_s2 && bias_s2;
			done_s4  <= done_s3;
			done_s5  <= done_s4;
			done_s6  <= done_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2) begin
			if (first_s2)
				acc_q <= ACC_W'(prod_s2);
			else
				acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	// round half up to Q12.12, then clamp to 24 bits
	always_comb begin
		acc_rnd = acc_q + ACC_W'(2048);
		acc_shr = acc_rnd[ACC_W-1:12];
		if (acc_shr > (ACC_W-12)'(PRE_MAX))
			sum_sat = PRE_MAX;
		else if (acc_shr < (ACC_W-12)'(PRE_MIN))
			sum_sat = PRE_MIN;
		else
			sum_sat = acc_shr[PRE_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (done_s3)
			sum_s4 <= sum_sat;
	end

	// segment lookup: offset from -8.0 in Q4.12
	always_comb begin
		off    = {~sum_s4[15], sum_s4[14:0]};
		seg    = {1'b0, off[15:11]};
		tab_lo = sig_tab(seg);
		tab_hi = sig_tab(seg + 6'd1);
		if (sum_s4 < -24'sd32768) begin
			lo_sel   = sig_tab(6'd0);
			diff_sel = '0;
			frac_sel = '0;
		end else if (sum_s4 >= 24'sd32768) begin
			lo_sel   = sig_tab(6'd32);
			diff_sel = '0;
			frac_sel = '0;
		end else begin
			lo_sel   = tab_lo;
			diff_sel = DIFF_W'(tab_hi - tab_lo);
			frac_sel = off[FRAC_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (done_s4) begin
			sum_s5  <= sum_s4;
			lo_s5   <= lo_sel;
			diff_s5 <= diff_sel;
			frac_s5 <= frac_sel;
		end
		if (done_s5) begin
			sum_s6    <= sum_s5;
			lo_s6     <= lo_s5;
			interp_s6 <= diff_s5 * frac_s5;
		end
	end

	assign interp_rnd = {1'b0, interp_s6} + (INTERP_W+1)'(1024);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (cmd.emit)
			out_valid <= 1'b1;
		else if (out_ready)
			out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_neuron <= cmd.neuron;
			out_last   <= cmd.last;
			out_pre    <= sum_s6;
			out_act    <= lo_s6 + ACT_W'(interp_rnd[INTERP_W:FRAC_W]);
		end
	end

	assign stat.done     = done_s6;
	assign stat.out_busy = out_valid && !out_ready;

endmodule

### design/dlsf_ctrl.sv
// Controller: sequences loads, the per-neuron MAC sweep, drain and result hand-off.
// Depends on dlsf_pkg; drives dlsf_datapath through dlsf_cmd_t.
`timescale 1ns / 1ps

module dlsf_ctrl import dlsf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [CMD_W-1:0] in_command,
	input  logic [SRC_W-1:0] source_size,
	input  logic [TGT_W-1:0] target_size,
	input  dlsf_stat_t       stat,
	output dlsf_cmd_t        cmd
);

	dlsf_state_t       state_q, state_d;
	logic [TERM_W-1:0] term_q, ns_q, ns_clamp;
	logic [NCNT_W-1:0] nt_q, nt_clamp;
	logic [NIDX_W-1:0] neuron_q;
	logic [WA_W-1:0]   base_q;
	logic              in_acc, start, mac_end, last_neuron;

	assign in_acc  = in_valid && in_ready;
	assign start   = in_acc && (in_command == CMD_RUN);
	assign mac_end = (term_q == ns_q);
	assign last_neuron = ({1'b0, neuron_q} == (nt_q - NCNT_W'(1)));

	// clamp the run size to what the stores hold
	always_comb begin
		if (source_size == '0)
			ns_clamp = TERM_W'(1);
		else if ({1'b0, source_size} > (SRC_W+1)'(MAX_INPUTS))
			ns_clamp = TERM_W'(MAX_INPUTS);
		else
			ns_clamp = TERM_W'(source_size);
		if (target_size == '0)
			nt_clamp = NCNT_W'(1);
		else if ({1'b0, target_size} > (TGT_W+1)'(MAX_OUTPUTS))
			nt_clamp = NCNT_W'(MAX_OUTPUTS);
		else
			nt_clamp = NCNT_W'(target_size);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (start) state_d = S_MAC;
			S_MAC:   if (mac_end) state_d = S_DRAIN;
			S_DRAIN: if (stat.done) state_d = S_EMIT;
			S_EMIT: begin
				if (!stat.out_busy)
					state_d = last_neuron ? S_IDLE : S_MAC;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready      = 1'b0;
		cmd           = '0;
		cmd.waddr     = WA_W'(base_q + WA_W'(term_q));
		cmd.xaddr     = term_q[XA_W-1:0];
		cmd.neuron    = NEU_W'(neuron_q);
		cmd.last      = last_neuron;
		case (state_q)
			S_IDLE: begin
				in_ready      = 1'b1;
				cmd.wr_weight = in_valid && (in_command == CMD_WEIGHT);
				cmd.wr_input  = in_valid && (in_command == CMD_INPUT);
			end
			S_MAC: begin
				cmd.mac_en = 1'b1;
				cmd.first  = (term_q == '0);
				cmd.bias   = mac_end;
			end
			S_EMIT: begin
				cmd.emit = !stat.out_busy;
			end
			default: begin
				cmd.emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			term_q   <= '0;
			ns_q     <= TERM_W'(1);
			nt_q     <= NCNT_W'(1);
			neuron_q <= '0;
			base_q   <= '0;
		end else begin
			state_q <= state_d;
			if (start) begin
				ns_q     <= ns_clamp;
				nt_q     <= nt_clamp;
				term_q   <= '0;
				neuron_q <= '0;
				base_q   <= '0;
			end else if (state_q == S_MAC && !mac_end) begin
				term_q <= term_q + TERM_W'(1);
			end else if (state_q == S_EMIT && !stat.out_busy && !last_neuron) begin
				term_q   <= '0;
				neuron_q <= neuron_q + NIDX_W'(1);
				base_q   <= base_q + WA_W'(ns_q) + WA_W'(1);
			end
		end
	end

	a_term_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MAC) |-> (term_q <= ns_q))
		else $error("term counter ran past the bias slot");

	a_done_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		stat.done |-> (state_q == S_DRAIN))
		else $error("sum finished outside the drain phase");

	a_neuron_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> ({1'b0, neuron_q} < nt_q))
		else $error("neuron counter ran past the run size");

	a_mac_to_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MAC && mac_end) |=> (state_q == S_DRAIN))
		else $error("bias term not followed by drain");

endmodule

### design/dense_layer_sigmoid_forward_unit.sv
// Dense layer with sigmoid: weight/input loads, run command, one result word per neuron.
// A run works neuron by neuron: the source_size inputs and then the bias pass through the
// single weight-memory read port and one multiplier, the pipeline drains (product, sum,
// round, table, interpolate) and the result word is emitted.
// The input is taken only between runs. Reset clears control and sets source_size to 64
// and target_size to 16; the weight and activation memories are not cleared.
`timescale 1ns / 1ps

module dense_layer_sigmoid_forward_unit import dlsf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	dlsf_in_if.sink     in_ch,
	dlsf_out_if.source  out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [SRC_W-1:0] source_size_q;
	logic [TGT_W-1:0] target_size_q;
	logic             cfg_wr;
	dlsf_cmd_t        cmd;
	dlsf_stat_t       stat;

	// APB: zero wait states; paddr[2] picks the register, byte offset bits are ignored
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_size_q <= SOURCE_RESET;
			target_size_q <= TARGET_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_SOURCE)
				source_size_q <= pwdata[SRC_W-1:0];
			else
				target_size_q <= pwdata[TGT_W-1:0];
		end
	end

	// read back zero-extended
	always_comb begin
		case (paddr[2])
			REG_SOURCE: prdata = {{(32-SRC_W){1'b0}}, source_size_q};
			REG_TARGET: prdata = {{(32-TGT_W){1'b0}}, target_size_q};
			default:    prdata = '0;
		endcase
	end

	// sequencer: owns the handshake on the input side and all counters
	dlsf_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_ch.valid),
		.in_ready    (in_ch.ready),
		.in_command  (in_ch.command),
		.source_size (source_size_q),
		.target_size (target_size_q),
		.stat        (stat),
		.cmd         (cmd)
	);

	// memories, MAC, sigmoid and the output register that holds a word until taken
	dlsf_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_index   (in_ch.index),
		.in_value   (in_ch.value),
		.out_ready  (out_ch.ready),
		.out_valid  (out_ch.valid),
		.out_neuron (out_ch.neuron),
		.out_pre    (out_ch.pre_activation),
		.out_act    (out_ch.activation),
		.out_last   (out_ch.last)
	);

endmodule

### verif/tb_top.sv
// Self-checking testbench for dense_layer_sigmoid_forward_unit: loads, runs and register setups.
// Depends on dlsf_pkg and the dlsf_in_if / dlsf_out_if interfaces from the design folder.
`timescale 1ns / 1ps

module tb_top;
	import dlsf_pkg::*;

	// timing and run bounds
	localparam int  HALF_PERIOD = 4;
	localparam int  RESET_CYCLES = 10;
	localparam int  SETTLE_CYCLES = 16;
	localparam int  TAIL_CYCLES = 32;
	localparam longint TIMEOUT_NS = 5_000_000;

	// the command code the block must drop
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	// register byte addresses, select bit sits at address bit 2
	localparam logic [2:0] SRC_ADDR = {REG_SOURCE, 2'b00};
	localparam logic [2:0] TGT_ADDR = {REG_TARGET, 2'b00};

	// sigmoid(k/2), k = -16..16, Q0.16
	localparam int unsigned SIGMOID_KNOTS [33] = '{
		22, 36, 60, 98, 162, 267, 439, 720,
		1179, 1921, 3108, 4971, 7812, 11955, 17625, 24743,
		32768,
		40793, 47911, 53581, 57724, 60565, 62428, 63615,
		64357, 64816, 65097, 65269, 65374, 65438, 65476, 65500,
		65514
	};

	typedef struct {
		logic [NEU_W-1:0]        neuron;
		logic signed [PRE_W-1:0] pre_activation;
		logic [ACT_W-1:0]        activation;
		logic                    last;
	} neuron_result_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	dlsf_in_if  in_ch ();
	dlsf_out_if out_ch ();

	dense_layer_sigmoid_forward_unit i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Shadow copy of the layer: both memories and the two size registers.
	logic signed [VAL_W-1:0] weight_mem [WEIGHT_DEPTH];
	logic signed [VAL_W-1:0] input_mem  [MAX_INPUTS];
	logic [SRC_W-1:0]        src_reg;
	logic [TGT_W-1:0]        tgt_reg;

	// neuron words predicted but not yet seen on the result channel, oldest first
	neuron_result_t predicted_neurons [$];

	// idling knobs, percent of cycles
	int send_idle_pct;
	int stall_pct;

	int mismatches;
	int words_sent;
	int layer_runs;
	int results_checked;
	int setups_done;

	initial begin
		clk = 1'b0;
	end

	always begin
		#(HALF_PERIOD) clk = ~clk;
	end

	// ------------------------------------------------------------------
	// prediction
	// ------------------------------------------------------------------

	// Sizes as the block uses them: out-of-range register values clamp.
	function automatic int used_sources();
		int s;
		s = src_reg;
		if (s < 1) s = 1;
		if (s > MAX_INPUTS) s = MAX_INPUTS;
		return s;
	endfunction

	function automatic int used_targets();
		int t;
		t = tgt_reg;
		if (t < 1) t = 1;
		if (t > MAX_OUTPUTS) t = MAX_OUTPUTS;
		return t;
	endfunction

	// Piecewise-linear sigmoid: 2048 LSB segments from -8.0, flat outside [-8, 8).
	function automatic logic [ACT_W-1:0] sigmoid_q16(input longint x);
		int unsigned off;
		int unsigned seg;
		int unsigned frac;
		int unsigned lo;
		int unsigned hi;
		if (x < -32768) return ACT_W'(SIGMOID_KNOTS[0]);
		if (x >= 32768) return ACT_W'(SIGMOID_KNOTS[32]);
		off = int'(x + 32768);
		seg = off >> 11;
		frac = off & 2047;
		lo = SIGMOID_KNOTS[seg];
		hi = SIGMOID_KNOTS[seg + 1];
		return ACT_W'(lo + (((hi - lo) * frac + 1024) >> 11));
	endfunction

	// One run: bias plus dot product per neuron, rounded half up to Q12.12, clamped.
	function automatic void predict_layer();
		int             ns;
		int             nt;
		int             row;
		longint         acc;
		longint         sum;
		neuron_result_t r;
		ns = used_sources();
		nt = used_targets();
		for (int j = 0; j < nt; j++) begin
			row = j * (ns + 1);
			// bias sits after the input weights, scaled from Q4.12 to Q8.24
			acc = longint'(weight_mem[row + ns]) * 4096;
			for (int i = 0; i < ns; i++) begin
				acc += longint'(weight_mem[row + i]) * longint'(input_mem[i]);
			end
			sum = (acc + 2048) >>> 12;
			if (sum > 8388607) sum = 8388607;
			if (sum < -8388608) sum = -8388608;
			r.neuron = NEU_W'(j);
			r.pre_activation = PRE_W'(sum);
			r.activation = sigmoid_q16(sum);
			r.last = (j == nt - 1);
			predicted_neurons.push_back(r);
		end
		layer_runs++;
	endfunction

	// Apply one accepted input word to the shadow state.
	function automatic void absorb_word(input logic [CMD_W-1:0] cmd,
			input logic [IDX_W-1:0] idx, input logic signed [VAL_W-1:0] val);
		case (cmd)
			CMD_WEIGHT: begin
				if (idx < WEIGHT_DEPTH) weight_mem[idx] = val;
			end
			CMD_INPUT: begin
				if (idx < MAX_INPUTS) input_mem[idx] = val;
			end
			CMD_RUN: begin
				predict_layer();
			end
			default: begin
				// unknown command: dropped by the block
			end
		endcase
	endfunction

	// ------------------------------------------------------------------
	// checking
	// ------------------------------------------------------------------

	function automatic void note_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 10) $display("MISMATCH at %0t ns: %s", $time, msg);
	endfunction

	function automatic void compare_register(input string name, input logic [31:0] got,
			input int width, input logic [31:0] want);
		logic [31:0] mask;
		mask = (32'd1 << width) - 32'd1;
		if ((got & mask) != (want & mask))
			note_mismatch($sformatf("%s readback: expected %0d, got %0d",
				name, want & mask, got & mask));
	endfunction

	function automatic void check_neuron_word();
		neuron_result_t want;
		if (predicted_neurons.size() == 0) begin
			note_mismatch($sformatf("unpredicted word: neuron %0d pre %0d act %0d last %0b",
				out_ch.neuron, out_ch.pre_activation, out_ch.activation, out_ch.last));
			return;
		end
		want = predicted_neurons.pop_front();
		results_checked++;
		if (out_ch.neuron !== want.neuron || out_ch.pre_activation !== want.pre_activation ||
				out_ch.activation !== want.activation || out_ch.last !== want.last)
			note_mismatch($sformatf(
				"expected n=%0d pre=%0d act=%0d last=%0b, got n=%0d pre=%0d act=%0d last=%0b",
				want.neuron, want.pre_activation, want.activation, want.last,
				out_ch.neuron, out_ch.pre_activation, out_ch.activation, out_ch.last));
	endfunction

	// Result side: check each accepted word, then pick ready for the next cycle.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) check_neuron_word();
			out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// ------------------------------------------------------------------
	// drivers
	// ------------------------------------------------------------------

	// Send one word; valid stays high afterwards unless the next call idles first.
	task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
			input logic signed [VAL_W-1:0] val);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.command <= cmd;
		in_ch.index <= idx;
		in_ch.value <= val;
		do @(posedge clk); while (!in_ch.ready);
		absorb_word(cmd, idx, val);
		words_sent++;
	endtask

	// Drop valid, wait for every predicted word, then let the block settle.
	task automatic drain_layer();
		in_ch.valid <= 1'b0;
		while (predicted_neurons.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One register access; psel is left high so accesses can chain.
	task automatic apb_access(input logic wr, input logic [2:0] addr,
			input logic [31:0] wdata, output logic [31:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
	endtask

	task automatic apb_release();
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Write both size registers while idle and read each one back.
	task automatic configure_layer(input logic [SRC_W-1:0] src, input logic [TGT_W-1:0] tgt);
		logic [31:0] rd;
		drain_layer();
		apb_access(1'b1, SRC_ADDR, {25'd0, src}, rd);
		src_reg = src;
		apb_access(1'b0, SRC_ADDR, 32'd0, rd);
		compare_register("source_size", rd, SRC_W, {25'd0, src});
		apb_access(1'b1, TGT_ADDR, {27'd0, tgt}, rd);
		tgt_reg = tgt;
		apb_access(1'b0, TGT_ADDR, 32'd0, rd);
		compare_register("target_size", rd, TGT_W, {27'd0, tgt});
		apb_release();
		setups_done++;
	endtask

	// Mix of full-range, small, mid-size and extreme Q4.12 values.
	function automatic logic signed [VAL_W-1:0] pick_value();
		logic [VAL_W-1:0] v;
		case ($urandom_range(0, 4))
			0: v = $urandom;
			1: v = $urandom_range(0, 4095) - 2048;
			2: v = $urandom_range(0, 16383) - 8192;
			3: begin
				case ($urandom_range(0, 3))
					0: v = 16'h8000;
					1: v = 16'h7FFF;
					2: v = 16'h0000;
					default: v = 16'hFFFF;
				endcase
			end
			default: v = $urandom_range(0, 1023) - 512;
		endcase
		return v;
	endfunction

	// Mostly small layers; now and then the largest or an out-of-range setting.
	function automatic logic [SRC_W-1:0] pick_source();
		case ($urandom_range(0, 9))
			0: return SRC_W'(MAX_INPUTS);
			1: return SRC_W'($urandom_range(0, 127));
			2: return '0;
			default: return SRC_W'($urandom_range(1, 8));
		endcase
	endfunction

	function automatic logic [TGT_W-1:0] pick_target();
		case ($urandom_range(0, 9))
			0: return TGT_W'(MAX_OUTPUTS);
			1: return TGT_W'($urandom_range(0, 31));
			default: return TGT_W'($urandom_range(1, 4));
		endcase
	endfunction

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// Write every memory entry once so no run ever reads an unwritten word.
	// With the reset stride, rows 0..3 alternate all -8.0 and all +8.0 weights and
	// the inputs are all -8.0, which drives those sums into both clamps.
	task automatic test_fill_stores();
		logic signed [VAL_W-1:0] v;
		for (int a = 0; a < WEIGHT_DEPTH; a++) begin
			if (a / (MAX_INPUTS + 1) < 4)
				v = ((a / (MAX_INPUTS + 1)) % 2 == 0) ? 16'sh8000 : 16'sh7FFF;
			else
				v = pick_value();
			send_word(CMD_WEIGHT, IDX_W'(a), v);
		end
		for (int i = 0; i < MAX_INPUTS; i++) begin
			send_word(CMD_INPUT, IDX_W'(i), 16'sh8000);
		end
	endtask

	// Read the reset sizes, then run the full-size layer they select.
	task automatic test_reset_state();
		logic [31:0] rd;
		drain_layer();
		apb_access(1'b0, SRC_ADDR, 32'd0, rd);
		compare_register("source_size after reset", rd, SRC_W, {25'd0, SOURCE_RESET});
		apb_access(1'b0, TGT_ADDR, 32'd0, rd);
		compare_register("target_size after reset", rd, TGT_W, {27'd0, TARGET_RESET});
		apb_release();
		send_word(CMD_RUN, '0, '0);
	endtask

	// Two inputs (1.0 and one LSB), six neurons aimed at the corners of the sigmoid:
	// exactly -8.0, a half LSB up and down (round half up), just under +8.0,
	// above +8.0 and below -8.0.
	task automatic test_sigmoid_edges();
		logic signed [VAL_W-1:0] rows [6][3] = '{
			'{16'sd0,      16'sd0,      16'sh8000},
			'{16'sd0,      16'sd2048,   16'sd0},
			'{16'sd0,      -16'sd2048,  16'sd0},
			'{16'sd0,      16'sd0,      16'sh7FFF},
			'{16'sh7FFF,   16'sd0,      16'sh7FFF},
			'{16'sh8000,   -16'sd2049,  16'sh8000}
		};
		configure_layer(SRC_W'(2), TGT_W'(6));
		send_word(CMD_INPUT, IDX_W'(0), 16'sd4096);
		send_word(CMD_INPUT, IDX_W'(1), 16'sd1);
		for (int j = 0; j < 6; j++) begin
			for (int c = 0; c < 3; c++) begin
				send_word(CMD_WEIGHT, IDX_W'(j * 3 + c), rows[j][c]);
			end
		end
		send_word(CMD_RUN, '0, '0);
	endtask

	// Words the block must drop: unknown command, indexes past either memory; then a run.
	task automatic test_ignored_words();
		send_word(CMD_UNUSED, IDX_W'(0), 16'sh7FFF);
		send_word(CMD_WEIGHT, IDX_W'(WEIGHT_DEPTH), 16'sh7FFF);
		send_word(CMD_WEIGHT, IDX_W'(2047), 16'sh8000);
		send_word(CMD_INPUT, IDX_W'(MAX_INPUTS), 16'sh7FFF);
		send_word(CMD_INPUT, IDX_W'(2047), 16'sh8000);
		send_word(CMD_RUN, IDX_W'(2047), 16'shFFFF);
	endtask

	// Register extremes: zero and all-ones clamp, then the largest in one dimension only.
	task automatic test_size_extremes();
		configure_layer('0, '0);
		send_word(CMD_RUN, '0, '0);
		configure_layer('1, '1);
		send_word(CMD_RUN, '0, '0);
		configure_layer(SRC_W'(MAX_INPUTS), TGT_W'(1));
		send_word(CMD_RUN, '0, '0);
		configure_layer(SRC_W'(1), TGT_W'(MAX_OUTPUTS));
		send_word(CMD_RUN, '0, '0);
	endtask

	// Random groups: optional resize, a burst of loads into the rows in use with
	// some noise mixed in, then a run. Only loads that land and runs count.
	task automatic test_random_traffic(input int send_pct, input int stall_in, input int words);
		int counted;
		int ns;
		int nt;
		int first_group;
		send_idle_pct = send_pct;
		stall_pct = stall_in;
		counted = 0;
		first_group = 1;
		while (counted < words) begin
			if (first_group || $urandom_range(0, 2) == 0) begin
				configure_layer(pick_source(), pick_target());
				first_group = 0;
			end
			ns = used_sources();
			nt = used_targets();
			repeat ($urandom_range(1, 8)) begin
				case ($urandom_range(0, 9))
					0: send_word(CMD_UNUSED, IDX_W'($urandom), pick_value());
					1: send_word(CMD_WEIGHT, IDX_W'($urandom), pick_value());
					2: send_word(CMD_INPUT, IDX_W'($urandom), pick_value());
					3, 4, 5: begin
						send_word(CMD_INPUT, IDX_W'($urandom_range(0, ns - 1)), pick_value());
						counted++;
					end
					default: begin
						send_word(CMD_WEIGHT, IDX_W'($urandom_range(0, nt - 1) * (ns + 1) +
							$urandom_range(0, ns)), pick_value());
						counted++;
					end
				endcase
			end
			// index and value carry no meaning on a run; drive them random anyway
			send_word(CMD_RUN, IDX_W'($urandom), pick_value());
			counted++;
		end
	endtask

	// ------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------

	initial begin
		// hold every block input at a known value from time zero
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.command = CMD_WEIGHT;
		in_ch.index = '0;
		in_ch.value = '0;
		out_ch.ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		src_reg = SOURCE_RESET;
		tgt_reg = TARGET_RESET;
		send_idle_pct = 0;
		stall_pct = 0;
		mismatches = 0;
		words_sent = 0;
		layer_runs = 0;
		results_checked = 0;
		setups_done = 0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part runs without idling on either side
		test_fill_stores();
		test_reset_state();
		test_sigmoid_edges();
		test_ignored_words();
		test_size_extremes();

		// random part: no idling, sender idle, receiver stalling, both
		test_random_traffic(0, 0, 30);
		test_random_traffic(60, 0, 30);
		test_random_traffic(0, 60, 30);
		test_random_traffic(32, 32, 30);

		drain_layer();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Covered %0d input words, %0d layer runs, %0d register setups.",
			words_sent, layer_runs, setups_done);
		$display("Checked %0d neuron words, %0d mismatches.", results_checked, mismatches);
		if (mismatches == 0 && predicted_neurons.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run, including stalls on both sides.
	initial begin
		#(TIMEOUT_NS);
		$display("Watchdog expired with %0d neuron words outstanding.",
			predicted_neurons.size());
		$display("FAIL");
		$finish;
	end

endmodule
